// File: rtl/qxmm_pkg.sv
// ----------------------------------------------------------------------------
// qxmm_pkg
// Types and constants shared by the quadrotor X motor mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package qxmm_pkg;

  localparam int unsigned IN_W      = 32;
  localparam int unsigned GAIN_W    = 40;
  localparam int unsigned SPEED_W   = 23;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned NUM_MOTOR = 4;

  localparam int unsigned PLO_W  = GAIN_W + 16;
  localparam int unsigned PHI_W  = GAIN_W + 17;
  localparam int unsigned TERM_W = GAIN_W + IN_W + 1;
  localparam int unsigned PAIR_W = TERM_W + 1;
  localparam int unsigned SUM_W  = TERM_W + 2;
  localparam int unsigned FRAC_W = 32;

  localparam int unsigned ROOT_W    = 24;
  localparam int unsigned RAD_W     = 2 * ROOT_W;
  localparam int unsigned REM_W     = ROOT_W + 2;
  localparam int unsigned SQ_STEPS  = 4;
  localparam int unsigned SQ_STAGES = ROOT_W / SQ_STEPS;

  localparam logic [GAIN_W-1:0] THRUST_GAIN_RST = 40'd19970044930;
  localparam logic [GAIN_W-1:0] TORQUE_GAIN_RST = 40'd613954560000;
  localparam logic [GAIN_W-1:0] DRAG_GAIN_RST   = 40'd3174489;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRUST_GAIN = 2'd0,
    REG_TORQUE_GAIN = 2'd1,
    REG_DRAG_GAIN   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [IN_W-1:0] thrust_cmd;
    logic signed [IN_W-1:0] roll_cmd;
    logic signed [IN_W-1:0] pitch_cmd;
    logic signed [IN_W-1:0] yaw_cmd;
  } in_item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_front_right;
    logic [SPEED_W-1:0] speed_rear_right;
    logic [SPEED_W-1:0] speed_rear_left;
    logic [SPEED_W-1:0] speed_front_left;
    logic               saturated;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/quadrotor_x_motor_mixer_unit.sv
// ----------------------------------------------------------------------------
// quadrotor_x_motor_mixer_unit
// Scales thrust and torques by their gains, mixes them in X pattern, clamps
// each motor sum and takes a pipelined square root per motor.
// ----------------------------------------------------------------------------
// pipeline: 4 arithmetic stages, then 6 square root stages of 4 root bits each
// throughput: one item per cycle; a held result stalls the whole pipeline
// reset: synchronous active-low, clears all valid bits and loads the gain
//   registers with their default values
`default_nettype none

module quadrotor_x_motor_mixer_unit (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  qxmm_pkg::in_item_t         in_data,
  output logic                             out_valid,
  input  wire                              out_stall,
  output qxmm_pkg::out_item_t              out_data,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [qxmm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [qxmm_pkg::GAIN_W-1:0]      cfg_data
);

  localparam int unsigned NM = qxmm_pkg::NUM_MOTOR;

  logic [qxmm_pkg::GAIN_W-1:0] thrust_gain_r;
  logic [qxmm_pkg::GAIN_W-1:0] torque_gain_r;
  logic [qxmm_pkg::GAIN_W-1:0] drag_gain_r;

  logic adv;
  logic v1_r, v2_r, v3_r, v4_r;

  logic        [qxmm_pkg::PLO_W-1:0]  pl_r   [NM];
  logic signed [qxmm_pkg::PHI_W-1:0]  ph_r   [NM];
  logic        [qxmm_pkg::PLO_W-1:0]  pl_nxt [NM];
  logic signed [qxmm_pkg::PHI_W-1:0]  ph_nxt [NM];
  logic signed [qxmm_pkg::TERM_W-1:0] term_r [NM];
  logic signed [qxmm_pkg::TERM_W-1:0] term_nxt [NM];
  logic signed [qxmm_pkg::PAIR_W-1:0] pair_r [NM];
  logic signed [qxmm_pkg::PAIR_W-1:0] pair_nxt [NM];
  logic        [qxmm_pkg::RAD_W-1:0]  rad4_r [NM];
  logic        [qxmm_pkg::RAD_W-1:0]  rad4_nxt [NM];
  logic                               sat4_r;
  logic                               sat4_nxt;

  logic                               qv_r    [qxmm_pkg::SQ_STAGES];
  logic                               qsat_r  [qxmm_pkg::SQ_STAGES];
  logic [qxmm_pkg::REM_W-1:0]         qrem_r  [qxmm_pkg::SQ_STAGES][NM];
  logic [qxmm_pkg::ROOT_W-1:0]        qroot_r [qxmm_pkg::SQ_STAGES][NM];
  logic [qxmm_pkg::RAD_W-1:0]         qrad_r  [qxmm_pkg::SQ_STAGES][NM];

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // gain registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thrust_gain_r <= qxmm_pkg::THRUST_GAIN_RST;
      torque_gain_r <= qxmm_pkg::TORQUE_GAIN_RST;
      drag_gain_r   <= qxmm_pkg::DRAG_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (qxmm_pkg::cfg_reg_t'(cfg_index))
        qxmm_pkg::REG_THRUST_GAIN: thrust_gain_r <= cfg_data;
        qxmm_pkg::REG_TORQUE_GAIN: torque_gain_r <= cfg_data;
        qxmm_pkg::REG_DRAG_GAIN:   drag_gain_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: partial products, gain times low and high input halves
  always_comb begin
    logic [qxmm_pkg::GAIN_W-1:0] gain [NM];
    logic [qxmm_pkg::IN_W-1:0]   val  [NM];
    logic signed [qxmm_pkg::PHI_W-1:0] ga;
    logic signed [qxmm_pkg::PHI_W-1:0] hb;
    gain[0] = thrust_gain_r;
    gain[1] = torque_gain_r;
    gain[2] = torque_gain_r;
    gain[3] = drag_gain_r;
    val[0]  = in_data.thrust_cmd;
    val[1]  = in_data.roll_cmd;
    val[2]  = in_data.pitch_cmd;
    val[3]  = in_data.yaw_cmd;
    for (int k = 0; k < NM; k++) begin
      pl_nxt[k] = qxmm_pkg::PLO_W'(gain[k]) * qxmm_pkg::PLO_W'(val[k][15:0]);
      ga = {17'b0, gain[k]};
      hb = {{(qxmm_pkg::PHI_W-16){val[k][qxmm_pkg::IN_W-1]}}, val[k][qxmm_pkg::IN_W-1:16]};
      ph_nxt[k] = ga * hb;
    end
  end

  // stage 2: full signed terms
  always_comb begin
    for (int k = 0; k < NM; k++) begin
      term_nxt[k] = $signed({ph_r[k], 16'b0}) + $signed({17'b0, pl_r[k]});
    end
  end

  // stage 3: pair sums t-r, t+r, p+y, p-y
  always_comb begin
    logic signed [qxmm_pkg::PAIR_W-1:0] t, r, p, y;
    t = {term_r[0][qxmm_pkg::TERM_W-1], term_r[0]};
    r = {term_r[1][qxmm_pkg::TERM_W-1], term_r[1]};
    p = {term_r[2][qxmm_pkg::TERM_W-1], term_r[2]};
    y = {term_r[3][qxmm_pkg::TERM_W-1], term_r[3]};
    pair_nxt[0] = t - r;
    pair_nxt[1] = t + r;
    pair_nxt[2] = p + y;
    pair_nxt[3] = p - y;
  end

  // stage 4: motor sums, floor, clamp, saturate
  always_comb begin
    logic signed [qxmm_pkg::SUM_W-1:0] a, b, c, d;
    logic signed [qxmm_pkg::SUM_W-1:0] m [NM];
    a = {pair_r[0][qxmm_pkg::PAIR_W-1], pair_r[0]};
    b = {pair_r[1][qxmm_pkg::PAIR_W-1], pair_r[1]};
    c = {pair_r[2][qxmm_pkg::PAIR_W-1], pair_r[2]};
    d = {pair_r[3][qxmm_pkg::PAIR_W-1], pair_r[3]};
    m[0] = a - c;
    m[1] = a + c;
    m[2] = b + d;
    m[3] = b - d;
    sat4_nxt = 1'b0;
    for (int k = 0; k < NM; k++) begin
      if (m[k][qxmm_pkg::SUM_W-1]) begin
        rad4_nxt[k] = '0;
      end else if (|m[k][qxmm_pkg::SUM_W-2:qxmm_pkg::FRAC_W+qxmm_pkg::GAIN_W]) begin
        rad4_nxt[k] = {2'b0, {qxmm_pkg::GAIN_W{1'b1}}, 6'b0};
        sat4_nxt    = 1'b1;
      end else begin
        rad4_nxt[k] = {2'b0, m[k][qxmm_pkg::FRAC_W+qxmm_pkg::GAIN_W-1:qxmm_pkg::FRAC_W], 6'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NM; k++) begin
        pl_r[k]   <= pl_nxt[k];
        ph_r[k]   <= ph_nxt[k];
        term_r[k] <= term_nxt[k];
        pair_r[k] <= pair_nxt[k];
        rad4_r[k] <= rad4_nxt[k];
      end
      sat4_r <= sat4_nxt;
    end
  end

  // square root stages, restoring, SQ_STEPS root bits per stage
  for (genvar g = 0; g < qxmm_pkg::SQ_STAGES; g++) begin : g_sq
    logic                        v_in;
    logic                        sat_in;
    logic [qxmm_pkg::REM_W-1:0]  rem_in   [NM];
    logic [qxmm_pkg::ROOT_W-1:0] root_in  [NM];
    logic [qxmm_pkg::RAD_W-1:0]  rad_in   [NM];
    logic [qxmm_pkg::REM_W-1:0]  rem_nxt  [NM];
    logic [qxmm_pkg::ROOT_W-1:0] root_nxt [NM];
    logic [qxmm_pkg::RAD_W-1:0]  rad_nxt  [NM];

    if (g == 0) begin : g_first
      assign v_in   = v4_r;
      assign sat_in = sat4_r;
      for (genvar k = 0; k < NM; k++) begin : g_lane
        assign rem_in[k]  = '0;
        assign root_in[k] = '0;
        assign rad_in[k]  = rad4_r[k];
      end
    end else begin : g_next
      assign v_in   = qv_r[g-1];
      assign sat_in = qsat_r[g-1];
      for (genvar k = 0; k < NM; k++) begin : g_lane
        assign rem_in[k]  = qrem_r[g-1][k];
        assign root_in[k] = qroot_r[g-1][k];
        assign rad_in[k]  = qrad_r[g-1][k];
      end
    end

    always_comb begin
      logic [qxmm_pkg::REM_W-1:0]  r;
      logic [qxmm_pkg::REM_W-1:0]  trial;
      logic [qxmm_pkg::ROOT_W-1:0] q;
      logic [qxmm_pkg::RAD_W-1:0]  d;
      for (int k = 0; k < NM; k++) begin
        r = rem_in[k];
        q = root_in[k];
        d = rad_in[k];
        for (int s = 0; s < qxmm_pkg::SQ_STEPS; s++) begin
          r     = {r[qxmm_pkg::REM_W-3:0], d[qxmm_pkg::RAD_W-1:qxmm_pkg::RAD_W-2]};
          trial = {q, 2'b01};
          d     = {d[qxmm_pkg::RAD_W-3:0], 2'b00};
          if (r >= trial) begin
            r = r - trial;
            q = {q[qxmm_pkg::ROOT_W-2:0], 1'b1};
          end else begin
            q = {q[qxmm_pkg::ROOT_W-2:0], 1'b0};
          end
        end
        rem_nxt[k]  = r;
        root_nxt[k] = q;
        rad_nxt[k]  = d;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        qv_r[g] <= 1'b0;
      end else if (adv) begin
        qv_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        qsat_r[g] <= sat_in;
        for (int k = 0; k < NM; k++) begin
          qrem_r[g][k]  <= rem_nxt[k];
          qroot_r[g][k] <= root_nxt[k];
          qrad_r[g][k]  <= rad_nxt[k];
        end
      end
    end
  end

  localparam int unsigned LAST = qxmm_pkg::SQ_STAGES - 1;

  assign out_valid                  = qv_r[LAST];
  assign out_data.speed_front_right = qroot_r[LAST][0][qxmm_pkg::SPEED_W-1:0];
  assign out_data.speed_rear_right  = qroot_r[LAST][1][qxmm_pkg::SPEED_W-1:0];
  assign out_data.speed_rear_left   = qroot_r[LAST][2][qxmm_pkg::SPEED_W-1:0];
  assign out_data.speed_front_left  = qroot_r[LAST][3][qxmm_pkg::SPEED_W-1:0];
  assign out_data.saturated         = qsat_r[LAST];

  // a saturated item has at least one motor at full speed
  a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturated) |->
      (&out_data.speed_front_right) || (&out_data.speed_rear_right) ||
      (&out_data.speed_rear_left) || (&out_data.speed_front_left))
    else $error("saturated item without a full-speed motor");

  // the front motor roots never reach the spare top bit
  a_root_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (qroot_r[LAST][0][qxmm_pkg::ROOT_W-1] == 1'b0) &&
                  (qroot_r[LAST][3][qxmm_pkg::ROOT_W-1] == 1'b0))
    else $error("square root overflow");

  // an item in stage one moves on when the pipeline advances
  a_v_move: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && adv) |=> v2_r)
    else $error("item lost between stage one and two");

  // a stalled pipeline holds its valid bits
  a_v_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(v4_r) && $stable(qv_r[0])))
    else $error("valid bit changed while stalled");

endmodule

`default_nettype wire

// File: dv/tb_quadrotor_x_motor_mixer_unit.sv
// ----------------------------------------------------------------------------
// tb_quadrotor_x_motor_mixer_unit
// Self-checking bench for the X-pattern motor mixer: drives thrust and torque
// commands under several gain settings and compares every speed result with
// an exact wide-integer prediction, with random idling on both channels.
// ----------------------------------------------------------------------------

module tb_quadrotor_x_motor_mixer_unit;

  localparam int unsigned GAIN_BITS = qxmm_pkg::GAIN_W;
  localparam logic [qxmm_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [qxmm_pkg::GAIN_W-1:0]    GAIN_MAX  = {qxmm_pkg::GAIN_W{1'b1}};
  localparam logic [qxmm_pkg::IN_W-1:0]      FIELD_MAX  = 32'h7FFF_FFFF;
  localparam logic [qxmm_pkg::IN_W-1:0]      FIELD_MIN  = 32'h8000_0000;
  localparam logic [qxmm_pkg::IN_W-1:0]      ONE_NEWTON = 32'h0100_0000;
  localparam int unsigned RANDOM_PHASES = 7;
  localparam int unsigned PHASE_ITEMS   = 150;
  localparam int unsigned SETTLE_CYCLES = 20;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  qxmm_pkg::in_item_t             in_data;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  qxmm_pkg::out_item_t            out_data;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [qxmm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [qxmm_pkg::GAIN_W-1:0]    cfg_data;

  logic [qxmm_pkg::GAIN_W-1:0] thrust_k;
  logic [qxmm_pkg::GAIN_W-1:0] torque_k;
  logic [qxmm_pkg::GAIN_W-1:0] drag_k;
  qxmm_pkg::out_item_t         speeds_due[$];
  int unsigned                 mismatches;
  int unsigned                 stall_left;
  bit                          quiet;

  quadrotor_x_motor_mixer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [31:0] int_sqrt(logic [63:0] x);
    logic [31:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = {32'd0, root | (32'd1 << i)};
      if (trial * trial <= x) root = trial[31:0];
    end
    return root;
  endfunction

  function automatic logic signed [127:0] scaled_term(logic [qxmm_pkg::GAIN_W-1:0] g,
                                                      logic [qxmm_pkg::IN_W-1:0] v);
    logic signed [127:0] gw;
    logic signed [127:0] vw;
    gw = {{(128-qxmm_pkg::GAIN_W){1'b0}}, g};
    vw = {{(128-qxmm_pkg::IN_W){v[qxmm_pkg::IN_W-1]}}, v};
    return gw * vw;
  endfunction

  // {saturated, speed} for one Q.32 motor sum
  function automatic logic [qxmm_pkg::SPEED_W:0] motor_root(logic signed [127:0] s);
    logic [127:0] whole;
    logic [31:0]  root;
    logic         sat;
    sat = 1'b0;
    if (s < 0) return '0;
    whole = s >> qxmm_pkg::FRAC_W;
    if (whole > {{(128-qxmm_pkg::GAIN_W){1'b0}}, GAIN_MAX}) begin
      whole = {{(128-qxmm_pkg::GAIN_W){1'b0}}, GAIN_MAX};
      sat = 1'b1;
    end
    root = int_sqrt({18'd0, whole[qxmm_pkg::GAIN_W-1:0], 6'd0});
    return {sat, root[qxmm_pkg::SPEED_W-1:0]};
  endfunction

  function automatic qxmm_pkg::out_item_t mix_motor_speeds(qxmm_pkg::in_item_t cmd);
    logic signed [127:0]        t;
    logic signed [127:0]        r;
    logic signed [127:0]        p;
    logic signed [127:0]        y;
    logic [qxmm_pkg::SPEED_W:0] m1;
    logic [qxmm_pkg::SPEED_W:0] m2;
    logic [qxmm_pkg::SPEED_W:0] m3;
    logic [qxmm_pkg::SPEED_W:0] m4;
    qxmm_pkg::out_item_t        res;
    t  = scaled_term(thrust_k, cmd.thrust_cmd);
    r  = scaled_term(torque_k, cmd.roll_cmd);
    p  = scaled_term(torque_k, cmd.pitch_cmd);
    y  = scaled_term(drag_k, cmd.yaw_cmd);
    m1 = motor_root(t - r - p - y);
    m2 = motor_root(t - r + p + y);
    m3 = motor_root(t + r + p - y);
    m4 = motor_root(t + r - p + y);
    res.speed_front_right = m1[qxmm_pkg::SPEED_W-1:0];
    res.speed_rear_right  = m2[qxmm_pkg::SPEED_W-1:0];
    res.speed_rear_left   = m3[qxmm_pkg::SPEED_W-1:0];
    res.speed_front_left  = m4[qxmm_pkg::SPEED_W-1:0];
    res.saturated         = m1[qxmm_pkg::SPEED_W] | m2[qxmm_pkg::SPEED_W] |
                            m3[qxmm_pkg::SPEED_W] | m4[qxmm_pkg::SPEED_W];
    return res;
  endfunction

  function automatic qxmm_pkg::in_item_t make_cmd(logic [qxmm_pkg::IN_W-1:0] t,
                                                  logic [qxmm_pkg::IN_W-1:0] r,
                                                  logic [qxmm_pkg::IN_W-1:0] p,
                                                  logic [qxmm_pkg::IN_W-1:0] y);
    qxmm_pkg::in_item_t res;
    res.thrust_cmd = t;
    res.roll_cmd   = r;
    res.pitch_cmd  = p;
    res.yaw_cmd    = y;
    return res;
  endfunction

  function automatic logic [qxmm_pkg::IN_W-1:0] rand_field();
    int v;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        v = int'($urandom_range(0, 33554432)) - 16777216;
        return v;
      end
      2: begin
        v = int'($urandom_range(0, 536870912)) - 268435456;
        return v;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: return FIELD_MAX;
          1: return FIELD_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  function automatic logic [qxmm_pkg::GAIN_W-1:0] rand_gain(logic [qxmm_pkg::GAIN_W-1:0] dflt);
    case ($urandom_range(0, 4))
      0: return dflt;
      1: return '0;
      2: return GAIN_MAX;
      3: return GAIN_BITS'({$urandom, $urandom});
      default: return GAIN_BITS'($urandom) << $urandom_range(0, 8);
    endcase
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
  endtask

  // item must be accepted once all earlier items are accepted
  task automatic send_command(qxmm_pkg::in_item_t cmd);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    speeds_due.push_back(mix_motor_speeds(cmd));
  endtask

  task automatic wait_idle();
    if (speeds_due.size() != 0) begin
      in_valid <= 1'b0;
      while (speeds_due.size() != 0) @(posedge clk);
    end
  endtask

  task automatic write_gain(logic [qxmm_pkg::CFG_IDX_W-1:0] idx,
                            logic [qxmm_pkg::GAIN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      qxmm_pkg::REG_THRUST_GAIN: thrust_k = value;
      qxmm_pkg::REG_TORQUE_GAIN: torque_k = value;
      qxmm_pkg::REG_DRAG_GAIN:   drag_k = value;
      default: ;
    endcase
  endtask

  task automatic load_gains(logic [qxmm_pkg::GAIN_W-1:0] t, logic [qxmm_pkg::GAIN_W-1:0] q,
                            logic [qxmm_pkg::GAIN_W-1:0] d, bit poke_spare);
    wait_idle();
    write_gain(qxmm_pkg::REG_THRUST_GAIN, t);
    if (poke_spare) write_gain(REG_SPARE, GAIN_BITS'({$urandom, $urandom}));
    write_gain(qxmm_pkg::REG_TORQUE_GAIN, q);
    write_gain(qxmm_pkg::REG_DRAG_GAIN, d);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_gains();
    send_command(make_cmd(ONE_NEWTON, 32'h0000_1000, 32'hFFFF_E000, 32'h0004_0000));
    send_command(make_cmd(32'h0080_0000, '0, '0, '0));
    send_command(make_cmd(FIELD_MAX, FIELD_MAX, FIELD_MIN, FIELD_MAX));
  endtask

  task automatic test_corners();
    qxmm_pkg::in_item_t corners[$];
    corners.push_back(make_cmd('0, '0, '0, '0));
    corners.push_back(make_cmd(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
    corners.push_back(make_cmd(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN));
    corners.push_back(make_cmd(FIELD_MAX, '0, '0, '0));
    corners.push_back(make_cmd(FIELD_MIN, '0, '0, '0));
    corners.push_back(make_cmd(FIELD_MAX, FIELD_MAX, FIELD_MIN, '0));
    corners.push_back(make_cmd(ONE_NEWTON, '0, '0, FIELD_MAX));
    corners.push_back(make_cmd(FIELD_MAX, '1, 32'd1, FIELD_MIN));
    // saturation on every motor path
    load_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, 1'b0);
    foreach (corners[i]) send_command(corners[i]);
    // zero thrust gain, writes to the unused index must not land
    load_gains('0, qxmm_pkg::TORQUE_GAIN_RST, GAIN_MAX, 1'b1);
    foreach (corners[i]) send_command(corners[i]);
    send_command(make_cmd(ONE_NEWTON, 32'h0001_0000, 32'h0002_0000, 32'h0010_0000));
  endtask

  task automatic test_random_mix();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: load_gains(qxmm_pkg::THRUST_GAIN_RST, qxmm_pkg::TORQUE_GAIN_RST,
                      qxmm_pkg::DRAG_GAIN_RST, 1'b0);
        1: load_gains(GAIN_MAX, '0, GAIN_MAX, 1'b1);
        2: load_gains(qxmm_pkg::THRUST_GAIN_RST, GAIN_MAX, '0, 1'b0);
        default: load_gains(rand_gain(qxmm_pkg::THRUST_GAIN_RST),
                            rand_gain(qxmm_pkg::TORQUE_GAIN_RST),
                            rand_gain(qxmm_pkg::DRAG_GAIN_RST),
                            1'($urandom_range(0, 1)));
      endcase
      quiet = (phase == RANDOM_PHASES - 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // let the pipeline empty completely once mid-phase
        if (phase == 3 && i == PHASE_ITEMS / 2) wait_idle();
        send_command(make_cmd(rand_field(), rand_field(), rand_field(), rand_field()));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_speeds
    qxmm_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (speeds_due.size() == 0) begin
        report_mismatch("unexpected item", 32'(out_data.speed_front_right), 0);
      end else begin
        want = speeds_due.pop_front();
        if (out_data.speed_front_right !== want.speed_front_right)
          report_mismatch("speed_front_right", 32'(out_data.speed_front_right),
                          32'(want.speed_front_right));
        if (out_data.speed_rear_right !== want.speed_rear_right)
          report_mismatch("speed_rear_right", 32'(out_data.speed_rear_right),
                          32'(want.speed_rear_right));
        if (out_data.speed_rear_left !== want.speed_rear_left)
          report_mismatch("speed_rear_left", 32'(out_data.speed_rear_left),
                          32'(want.speed_rear_left));
        if (out_data.speed_front_left !== want.speed_front_left)
          report_mismatch("speed_front_left", 32'(out_data.speed_front_left),
                          32'(want.speed_front_left));
        if (out_data.saturated !== want.saturated)
          report_mismatch("saturated", 32'(out_data.saturated), 32'(want.saturated));
      end
    end
  end

  initial begin
    #4000000;
    $display("quadrotor_x_motor_mixer_unit verification failed");
    $finish;
  end

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    quiet      = 1'b0;
    mismatches = 0;
    thrust_k   = qxmm_pkg::THRUST_GAIN_RST;
    torque_k   = qxmm_pkg::TORQUE_GAIN_RST;
    drag_k     = qxmm_pkg::DRAG_GAIN_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_gains();
    test_corners();
    test_random_mix();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("quadrotor_x_motor_mixer_unit verification clean");
    end else begin
      $display("quadrotor_x_motor_mixer_unit verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/qxmm_pkg.sv
rtl/quadrotor_x_motor_mixer_unit.sv
dv/tb_quadrotor_x_motor_mixer_unit.sv
